// File: hdl/ialog_pkg.sv
// ----------------------------------------------------------------------------
// ialog_pkg
// Shared constants, types and the microcode table of the interval
// average / minimum / maximum logger.
// ----------------------------------------------------------------------------
package ialog_pkg;

    // Block configuration
    localparam int WINDOW_MAX = 128;
    localparam int LOG_DEPTH  = 64;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 8;
    localparam int LOG_SLOT_W = 6;

    // Derived widths
    localparam int TALLY_W   = $clog2(WINDOW_MAX + 1);
    localparam int ACC_W     = $clog2(WINDOW_MAX * ((2 ** SAMPLE_W) - 1) + 1);
    localparam int SLOT_W    = (LOG_DEPTH > 2) ? $clog2(LOG_DEPTH) : 1;
    localparam int DIV_STEPS = ACC_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [SAMPLE_W-1:0] MARK_ALL_ONES = '1;

    // Program counter
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_FETCH    = 3'd0;
    localparam t_pc PC_ACCUM    = 3'd1;
    localparam t_pc PC_DIV_INIT = 3'd2;
    localparam t_pc PC_DIV_STEP = 3'd3;
    localparam t_pc PC_EMIT     = 3'd4;
    localparam t_pc PC_CLEAR    = 3'd5;

    // Jump conditions: jump to target when true, else fall through
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_IN,
        C_NOT_CLOSE,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    // One control word
    typedef struct packed {
        logic  in_rdy;
        logic  acc;
        logic  div_init;
        logic  div_step;
        logic  emit;
        logic  clear;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic closing;
        logic div_more;
        logic out_busy;
    } t_stat;

    localparam t_uword UW_NOP = '{
        in_rdy:   1'b0,
        acc:      1'b0,
        div_init: 1'b0,
        div_step: 1'b0,
        emit:     1'b0,
        clear:    1'b0,
        cond:     C_ALWAYS,
        target:   PC_FETCH
    };

    // Microcode ROM
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            PC_FETCH: begin
                w.in_rdy = 1'b1;
                w.cond   = C_NO_IN;
                w.target = PC_FETCH;
            end
            PC_ACCUM: begin
                w.acc    = 1'b1;
                w.cond   = C_NOT_CLOSE;
                w.target = PC_FETCH;
            end
            PC_DIV_INIT: begin
                w.div_init = 1'b1;
                w.cond     = C_NEXT;
            end
            PC_DIV_STEP: begin
                w.div_step = 1'b1;
                w.cond     = C_DIV_MORE;
                w.target   = PC_DIV_STEP;
            end
            PC_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = PC_EMIT;
            end
            PC_CLEAR: begin
                w.clear  = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = PC_FETCH;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hdl/interval_avg_min_max_logger_top.sv
// ----------------------------------------------------------------------------
// interval_avg_min_max_logger_top
// Per-interval average, minimum and maximum of paired light and temperature
// samples, with log slot, sticky full flag and window overflow flag.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------------
//   sample   | in        | i_in_valid / o_in_ready | light, temp, end_of_interval
//   record   | out       | o_out_valid/i_out_ready | averages, min, max, count,
//            |           |                         | slot, full, overflow
//
// A sample that does not close the interval passes the fetch and accumulate steps.
// A closing sample then passes divider init, divide, emit and clear: the two
// restoring dividers produce one quotient bit per cycle over the ACC_W-bit sum.
// The emit step holds while the output register still carries an untaken
// record; the next request is accepted as soon as the clear step is done.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_avg_min_max_logger_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ialog_pkg::SAMPLE_W-1:0]    i_light_sample,
    input  logic [ialog_pkg::SAMPLE_W-1:0]    i_temp_sample,
    input  logic                              i_end_of_interval,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_light_average,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_light_minimum,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_light_maximum,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_temp_average,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_temp_minimum,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_temp_maximum,
    output logic [ialog_pkg::COUNT_W-1:0]     o_samples_in_interval,
    output logic [ialog_pkg::LOG_SLOT_W-1:0]  o_log_slot,
    output logic                              o_log_full,
    output logic                              o_window_overflow
);
    import ialog_pkg::*;

    t_uword w_ctrl;
    t_stat  w_stat;

    assign o_in_ready = w_ctrl.in_rdy;

    // Sequencer
    ialog_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    // Datapath
    ialog_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_ctrl                (w_ctrl),
        .o_stat                (w_stat),
        .i_in_valid            (i_in_valid),
        .i_light_sample        (i_light_sample),
        .i_temp_sample         (i_temp_sample),
        .i_end_of_interval     (i_end_of_interval),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_light_average       (o_light_average),
        .o_light_minimum       (o_light_minimum),
        .o_light_maximum       (o_light_maximum),
        .o_temp_average        (o_temp_average),
        .o_temp_minimum        (o_temp_minimum),
        .o_temp_maximum        (o_temp_maximum),
        .o_samples_in_interval (o_samples_in_interval),
        .o_log_slot            (o_log_slot),
        .o_log_full            (o_log_full),
        .o_window_overflow     (o_window_overflow)
    );

endmodule

// File: hdl/ialog_seq.sv
// ----------------------------------------------------------------------------
// ialog_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module ialog_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ialog_pkg::t_stat i_stat,
    output ialog_pkg::t_uword o_ctrl
);
    import ialog_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_jump;

    // Control word of the current step
    assign w_word = ucode(r_pc);
    assign o_ctrl = w_word;

    // Jump condition
    always_comb begin
        unique case (w_word.cond)
            C_NEXT:      w_jump = 1'b0;
            C_ALWAYS:    w_jump = 1'b1;
            C_NO_IN:     w_jump = !(i_in_valid && w_word.in_rdy);
            C_NOT_CLOSE: w_jump = !i_stat.closing;
            C_DIV_MORE:  w_jump = i_stat.div_more;
            C_OUT_BUSY:  w_jump = i_stat.out_busy;
            default:     w_jump = 1'b1;
        endcase
    end

    // Next step
    always_comb begin
        if (w_jump) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hdl/ialog_div.sv
// ----------------------------------------------------------------------------
// ialog_div
// Restoring divider, one quotient bit per step: sum / sample count.
// ----------------------------------------------------------------------------
module ialog_div (
    input  logic                           i_clk,
    input  logic                           i_init,
    input  logic                           i_step,
    input  logic [ialog_pkg::ACC_W-1:0]    i_num,
    input  logic [ialog_pkg::TALLY_W-1:0]  i_den,
    output logic [ialog_pkg::ACC_W-1:0]    o_quo
);
    import ialog_pkg::*;

    logic [ACC_W-1:0]   r_quo;
    logic [TALLY_W-1:0] r_rem;
    logic [TALLY_W:0]   w_rem_sh;
    logic [TALLY_W:0]   w_diff;
    logic               w_ge;

    // Trial subtract
    assign w_rem_sh = {r_rem, r_quo[ACC_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, i_den};
    assign w_diff   = w_rem_sh - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (i_step) begin
            r_quo <= {r_quo[ACC_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[TALLY_W-1:0] : w_rem_sh[TALLY_W-1:0];
        end
    end

    assign o_quo = r_quo;

endmodule

// File: hdl/ialog_dp.sv
// ----------------------------------------------------------------------------
// ialog_dp
// Datapath: sample latch, sums, marks, tally, slot, dividers, output register.
// ----------------------------------------------------------------------------
module ialog_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ialog_pkg::t_uword                 i_ctrl,
    output ialog_pkg::t_stat                  o_stat,
    input  logic                              i_in_valid,
    input  logic [ialog_pkg::SAMPLE_W-1:0]    i_light_sample,
    input  logic [ialog_pkg::SAMPLE_W-1:0]    i_temp_sample,
    input  logic                              i_end_of_interval,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_light_average,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_light_minimum,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_light_maximum,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_temp_average,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_temp_minimum,
    output logic [ialog_pkg::SAMPLE_W-1:0]    o_temp_maximum,
    output logic [ialog_pkg::COUNT_W-1:0]     o_samples_in_interval,
    output logic [ialog_pkg::LOG_SLOT_W-1:0]  o_log_slot,
    output logic                              o_log_full,
    output logic                              o_window_overflow
);
    import ialog_pkg::*;

    // Latched request
    logic [SAMPLE_W-1:0] r_light_in;
    logic [SAMPLE_W-1:0] r_temp_in;
    logic                r_closing;

    // Interval state
    logic [ACC_W-1:0]    r_light_acc;
    logic [ACC_W-1:0]    r_temp_acc;
    logic [SAMPLE_W-1:0] r_light_min;
    logic [SAMPLE_W-1:0] r_light_max;
    logic [SAMPLE_W-1:0] r_temp_min;
    logic [SAMPLE_W-1:0] r_temp_max;
    logic [TALLY_W-1:0]  r_tally;
    logic                r_ovf;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_full;
    logic [DCNT_W-1:0]   r_dcnt;
    logic                r_out_valid;

    logic [ACC_W-1:0]    w_light_quo;
    logic [ACC_W-1:0]    w_temp_quo;
    logic                w_in_acc;
    logic                w_room;
    logic                w_out_busy;
    logic                w_fire;
    logic                w_wrap;
    logic [SLOT_W-1:0]   n_slot;
    logic                n_full;

    assign w_in_acc   = i_in_valid && i_ctrl.in_rdy;
    assign w_room     = r_tally < TALLY_W'(WINDOW_MAX);
    assign w_out_busy = r_out_valid && !i_out_ready;
    assign w_fire     = i_ctrl.emit && !w_out_busy;

    assign o_stat.closing  = r_closing;
    assign o_stat.div_more = r_dcnt != DCNT_W'(1);
    assign o_stat.out_busy = w_out_busy;

    // Input latch
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_light_in <= i_light_sample;
            r_temp_in  <= i_temp_sample;
            r_closing  <= i_end_of_interval;
        end
    end

    // Accumulate or flag a dropped sample; clear after emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_light_acc <= '0;
            r_temp_acc  <= '0;
            r_light_min <= MARK_ALL_ONES;
            r_light_max <= '0;
            r_temp_min  <= MARK_ALL_ONES;
            r_temp_max  <= '0;
            r_tally     <= '0;
            r_ovf       <= 1'b0;
        end else if (i_ctrl.acc) begin
            if (w_room) begin
                r_light_acc <= r_light_acc + ACC_W'(r_light_in);
                r_temp_acc  <= r_temp_acc + ACC_W'(r_temp_in);
                if (r_light_in < r_light_min) begin
                    r_light_min <= r_light_in;
                end
                if (r_light_in > r_light_max) begin
                    r_light_max <= r_light_in;
                end
                if (r_temp_in < r_temp_min) begin
                    r_temp_min <= r_temp_in;
                end
                if (r_temp_in > r_temp_max) begin
                    r_temp_max <= r_temp_in;
                end
                r_tally <= r_tally + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Divide step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_ctrl.div_init) begin
            r_dcnt <= DCNT_W'(DIV_STEPS);
        end else if (i_ctrl.div_step) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    // Both channels divide by the same tally in lockstep
    ialog_div u_light_div (
        .i_clk  (i_clk),
        .i_init (i_ctrl.div_init),
        .i_step (i_ctrl.div_step),
        .i_num  (r_light_acc),
        .i_den  (r_tally),
        .o_quo  (w_light_quo)
    );

    ialog_div u_temp_div (
        .i_clk  (i_clk),
        .i_init (i_ctrl.div_init),
        .i_step (i_ctrl.div_step),
        .i_num  (r_temp_acc),
        .i_den  (r_tally),
        .o_quo  (w_temp_quo)
    );

    // Slot advance with wrap and sticky full
    always_comb begin
        w_wrap = r_slot == SLOT_W'(LOG_DEPTH - 1);
        n_slot = w_wrap ? '0 : r_slot + 1'b1;
        n_full = r_full || w_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
        end else if (w_fire) begin
            r_slot <= n_slot;
            r_full <= n_full;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_light_average       <= SAMPLE_W'(w_light_quo);
            o_light_minimum       <= r_light_min;
            o_light_maximum       <= r_light_max;
            o_temp_average        <= SAMPLE_W'(w_temp_quo);
            o_temp_minimum        <= r_temp_min;
            o_temp_maximum        <= r_temp_max;
            o_samples_in_interval <= COUNT_W'(r_tally);
            o_log_slot            <= LOG_SLOT_W'(r_slot);
            o_log_full            <= n_full;
            o_window_overflow     <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div_init |-> r_tally != '0)
        else $error("division started with zero sample count");

    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= TALLY_W'(WINDOW_MAX))
        else $error("sample tally above window limit");

    a_marks_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally != '0 |-> (r_light_min <= r_light_max && r_temp_min <= r_temp_max))
        else $error("minimum above maximum in a non-empty interval");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("emitted record not presented");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> (r_tally == '0 && !r_ovf))
        else $error("interval state not cleared");

endmodule
